// File: src/ftq_pkg.sv
// ----------------------------------------------------------------------------
// ftq_pkg
// Shared types and constants of the first-taller-to-right query block.
// ----------------------------------------------------------------------------
package ftq_pkg;

  // default table geometry
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int VALUE_WIDTH_DEF = 32;

  // fixed field widths
  localparam int POS_W = 10;
  localparam int CNT_W = 11;

  // entry count after reset
  localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

  // request operation codes
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // query token that walks down the cell row
  typedef struct packed {
    logic             vld;
    logic             done;
    logic             found;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    logic [POS_W-1:0] pos;
  } token_t;

endpackage

// File: src/ftq_cell.sv
// ----------------------------------------------------------------------------
// ftq_cell
// One table entry plus one stage of the query token path. The cell picks up
// the low-position value, resolves at the high position, and checks the
// scan condition past the high position.
// ----------------------------------------------------------------------------
module ftq_cell #(
  parameter int TABLE_DEPTH = ftq_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = ftq_pkg::VALUE_WIDTH_DEF,
  parameter int CELL_INDEX  = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [ftq_pkg::POS_W-1:0]   wr_index,
  input  logic [VALUE_WIDTH-1:0]      wr_value,
  input  logic [ftq_pkg::CNT_W-1:0]   count,
  input  ftq_pkg::token_t             tok_i,
  input  logic [VALUE_WIDTH-1:0]      vlo_i,
  output ftq_pkg::token_t             tok_o,
  output logic [VALUE_WIDTH-1:0]      vlo_o
);
  import ftq_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CMP_W = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
  localparam logic [CMP_W-1:0] K_C = CMP_W'(CELL_INDEX);

  logic [VALUE_WIDTH-1:0] value_r;
  token_t                 tok_r;
  token_t                 tok_nxt;
  logic [VALUE_WIDTH-1:0] vlo_r;
  logic [VALUE_WIDTH-1:0] vlo_nxt;
  logic                   is_lo;
  logic                   is_hi;
  logic                   past_hi;
  logic                   in_range;

  // entry write from a load request
  always_ff @(posedge clk) begin
    if (wr_en && (CMP_W'(wr_index) == K_C)) begin
      value_r <= wr_value;
    end
  end

  // position decode against this cell
  assign is_lo    = (CMP_W'(tok_i.lo) == K_C);
  assign is_hi    = (CMP_W'(tok_i.hi) == K_C);
  assign past_hi  = (K_C > CMP_W'(tok_i.hi));
  assign in_range = (K_C < CMP_W'(count));

  // token update
  always_comb begin
    tok_nxt = tok_i;
    vlo_nxt = vlo_i;
    if (tok_i.vld && !tok_i.done) begin
      if (is_lo) begin
        vlo_nxt = value_r;
      end
      if (is_hi && (vlo_i < value_r)) begin
        tok_nxt.done  = 1'b1;
        tok_nxt.found = 1'b1;
        tok_nxt.pos   = tok_i.hi;
      end
      if (past_hi && in_range && (value_r > vlo_i)) begin
        tok_nxt.done  = 1'b1;
        tok_nxt.found = 1'b1;
        tok_nxt.pos   = K_C[POS_W-1:0];
      end
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      vlo_r <= vlo_nxt;
    end
  end

  assign tok_o = tok_r;
  assign vlo_o = vlo_r;

endmodule

// File: src/ftq_chain.sv
// ----------------------------------------------------------------------------
// ftq_chain
// Row of table cells. The query token enters cell zero and moves one cell
// per cycle; the row output carries the resolved token.
// ----------------------------------------------------------------------------
module ftq_chain #(
  parameter int TABLE_DEPTH = ftq_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = ftq_pkg::VALUE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [ftq_pkg::POS_W-1:0]   wr_index,
  input  logic [VALUE_WIDTH-1:0]      wr_value,
  input  logic [ftq_pkg::CNT_W-1:0]   count,
  input  ftq_pkg::token_t             tok_i,
  output ftq_pkg::token_t             tok_o
);
  import ftq_pkg::*;

  token_t                 tok_link [0:TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] vlo_link [0:TABLE_DEPTH];

  // token enters with no low value picked up yet
  assign tok_link[0] = tok_i;
  assign vlo_link[0] = '0;

  // cell row
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    ftq_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .CELL_INDEX  (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (wr_en),
      .wr_index (wr_index),
      .wr_value (wr_value),
      .count    (count),
      .tok_i    (tok_link[g]),
      .vlo_i    (vlo_link[g]),
      .tok_o    (tok_link[g+1]),
      .vlo_o    (vlo_link[g+1])
    );
  end

  assign tok_o = tok_link[TABLE_DEPTH];

endmodule

// File: src/first_taller_to_right_query.sv
// ----------------------------------------------------------------------------
// first_taller_to_right_query
// Leftmost greater element query over a table held in a row of cells.
// ----------------------------------------------------------------------------
// A load request writes one entry. A query with equal positions is answered
// directly through the result register. Any other query sends a token down
// the row of TABLE_DEPTH cells, one cell per cycle; its result passes the
// injection register, the cell registers and the result register, and no new
// request is taken while the token is in the row. Only one query is in
// flight at a time. The table needs no clearing pass.
// ----------------------------------------------------------------------------
module first_taller_to_right_query #(
  parameter int TABLE_DEPTH = ftq_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = ftq_pkg::VALUE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_op,
  input  logic [ftq_pkg::POS_W-1:0]   in_load_index,
  input  logic [VALUE_WIDTH-1:0]      in_load_value,
  input  logic [ftq_pkg::POS_W-1:0]   in_first_position,
  input  logic [ftq_pkg::POS_W-1:0]   in_second_position,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_found,
  output logic [ftq_pkg::POS_W-1:0]   out_meet_position,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ftq_pkg::CNT_W-1:0]   cfg_entry_count
);
  import ftq_pkg::*;

  logic             busy_r;
  logic             busy_nxt;
  logic [CNT_W-1:0] count_r;
  token_t           inj_r;
  token_t           inj_nxt;
  token_t           chain_out;
  logic             out_valid_r;
  logic             out_found_r;
  logic [POS_W-1:0] out_pos_r;
  logic             in_accept;
  logic             is_query;
  logic             same_pos;
  logic             load_en;
  logic             a_lt_b;

  // request handshake
  assign in_stall  = busy_r || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign is_query  = (in_op == OP_QUERY);
  assign same_pos  = (in_first_position == in_second_position);
  assign load_en   = in_accept && (in_op == OP_LOAD);
  assign a_lt_b    = (in_first_position < in_second_position);

  // entry count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      count_r <= cfg_entry_count;
    end
  end

  assign cfg_ready = !busy_r;

  // token injection
  always_comb begin
    inj_nxt       = '0;
    inj_nxt.lo    = a_lt_b ? in_first_position : in_second_position;
    inj_nxt.hi    = a_lt_b ? in_second_position : in_first_position;
    inj_nxt.vld   = in_accept && is_query && !same_pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inj_r.vld <= 1'b0;
    end else begin
      inj_r <= inj_nxt;
    end
  end

  // busy while a token is in the row
  always_comb begin
    busy_nxt = busy_r;
    if (inj_nxt.vld) begin
      busy_nxt = 1'b1;
    end else if (chain_out.vld) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // cell row
  ftq_chain #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (load_en),
    .wr_index (in_load_index),
    .wr_value (in_load_value),
    .count    (count_r),
    .tok_i    (inj_r),
    .tok_o    (chain_out)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (chain_out.vld) begin
      out_valid_r <= 1'b1;
    end else if (in_accept && is_query && same_pos) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chain_out.vld) begin
      out_found_r <= chain_out.found;
      out_pos_r   <= chain_out.found ? chain_out.pos : '0;
    end else if (in_accept && is_query && same_pos) begin
      out_found_r <= 1'b1;
      out_pos_r   <= in_first_position;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_meet_position = out_pos_r;

  // no pending result while a token is in the row
  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !out_valid_r)
    else $error("result pending while query in flight");

  // row output only for a query in flight
  a_chain_busy: assert property (@(posedge clk) disable iff (!rst_n)
    chain_out.vld |-> busy_r)
    else $error("row output without query in flight");

  // a miss reports position zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_found_r || (out_pos_r == '0)))
    else $error("miss with nonzero position");

endmodule
